// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the command frame sender.
// Builds that define NO_ASSERTIONS get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define HCFS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

`define HCFS_ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen");

`else

`define HCFS_ASSERT(label, clk, rst_n, prop)

`define HCFS_ASSERT_NEVER(label, clk, rst_n, prop)

`endif

`endif

// ===== sv/hcfs_pkg.sv =====
// Types and constants of the command frame sender.
// Used by the channel interfaces, the frame engine and the top level.
package hcfs_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_GET   = 2'd1,
    OP_SET   = 2'd2,
    OP_DELAY = 2'd3
  } op_e;

  localparam int FrameMax = 12;
  localparam int ByteIdxW = 4;
  localparam logic [ByteIdxW-1:0] FrameMaxIdx = ByteIdxW'(FrameMax);

  localparam logic [7:0] SyncHi = 8'hAA;
  localparam logic [7:0] SyncLo = 8'h55;

  localparam logic [7:0] LenByteGet   = 8'h09;
  localparam logic [7:0] LenByteSet   = 8'h06;
  localparam logic [7:0] LenByteDelay = 8'h03;

  localparam logic [7:0] CmdGet   = 8'h00;
  localparam logic [7:0] CmdSet   = 8'h01;
  localparam logic [7:0] CmdDelay = 8'h02;

  localparam logic [ByteIdxW-1:0] FrameLenGet   = 4'd12;
  localparam logic [ByteIdxW-1:0] FrameLenSet   = 4'd9;
  localparam logic [ByteIdxW-1:0] FrameLenDelay = 4'd6;

  typedef struct packed {
    op_e         op;
    logic        data_line;
    logic [31:0] target_address;
    logic [31:0] byte_count;
    logic [7:0]  write_value;
    logic [15:0] delay_value;
  } cmd_t;

  typedef struct packed {
    logic clock_line;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } res_t;

  typedef struct packed {
    logic sending;
    logic clock_level;
    logic waiting_for_low;
  } status_t;

endpackage

// ===== sv/hcfs_if.sv =====
// Valid/ready channel interfaces for command items and result items.
// Depends on hcfs_pkg for the payload types.
interface hcfs_cmd_if;
  logic              valid;
  logic              ready;
  hcfs_pkg::cmd_t    data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hcfs_res_if;
  logic              valid;
  logic              ready;
  hcfs_pkg::res_t    data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/hcfs_engine.sv =====
// Frame store and bit sequencer of the command frame sender.
// Depends on hcfs_pkg; advances its state once per stepped command.
module hcfs_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  hcfs_pkg::cmd_t     item_i,
  output hcfs_pkg::res_t     res_o,
  output hcfs_pkg::status_t  status_o
);

  logic [7:0]                    frame_bytes_q [hcfs_pkg::FrameMax];
  logic [7:0]                    frame_bytes_d [hcfs_pkg::FrameMax];
  logic [hcfs_pkg::ByteIdxW-1:0] frame_length_q, frame_length_d;
  logic [hcfs_pkg::ByteIdxW-1:0] byte_position_q, byte_position_d;
  logic [2:0]                    bit_position_q, bit_position_d;
  logic                          waiting_for_low_q, waiting_for_low_d;
  logic                          sending_q, sending_d;
  logic                          clock_level_q, clock_level_d;
  logic [7:0]                    cur_byte;
  logic                          cur_bit;
  logic [hcfs_pkg::ByteIdxW-1:0] byte_next;
  logic                          done;
  logic                          rej;

  always_comb begin
    frame_bytes_d     = frame_bytes_q;
    frame_length_d    = frame_length_q;
    byte_position_d   = byte_position_q;
    bit_position_d    = bit_position_q;
    waiting_for_low_d = waiting_for_low_q;
    sending_d         = sending_q;
    clock_level_d     = clock_level_q;
    done              = 1'b0;
    rej               = 1'b0;
    byte_next         = byte_position_q + 4'd1;

    if (byte_position_q < hcfs_pkg::FrameMaxIdx) begin
      cur_byte = frame_bytes_q[byte_position_q];
    end else begin
      cur_byte = 8'h00;
    end
    cur_bit = cur_byte[3'd7 - bit_position_q];

    if (step_i) begin
      if (item_i.op != hcfs_pkg::OP_TICK) begin
        if (sending_q) begin
          rej = 1'b1;
        end else begin
          frame_bytes_d[0] = hcfs_pkg::SyncHi;
          frame_bytes_d[1] = hcfs_pkg::SyncLo;
          unique case (item_i.op)
            hcfs_pkg::OP_GET: begin
              frame_bytes_d[2]  = hcfs_pkg::LenByteGet;
              frame_bytes_d[3]  = hcfs_pkg::CmdGet;
              frame_bytes_d[4]  = item_i.target_address[31:24];
              frame_bytes_d[5]  = item_i.target_address[23:16];
              frame_bytes_d[6]  = item_i.target_address[15:8];
              frame_bytes_d[7]  = item_i.target_address[7:0];
              frame_bytes_d[8]  = item_i.byte_count[31:24];
              frame_bytes_d[9]  = item_i.byte_count[23:16];
              frame_bytes_d[10] = item_i.byte_count[15:8];
              frame_bytes_d[11] = item_i.byte_count[7:0];
              frame_length_d    = hcfs_pkg::FrameLenGet;
            end
            hcfs_pkg::OP_SET: begin
              frame_bytes_d[2] = hcfs_pkg::LenByteSet;
              frame_bytes_d[3] = hcfs_pkg::CmdSet;
              frame_bytes_d[4] = item_i.target_address[31:24];
              frame_bytes_d[5] = item_i.target_address[23:16];
              frame_bytes_d[6] = item_i.target_address[15:8];
              frame_bytes_d[7] = item_i.target_address[7:0];
              frame_bytes_d[8] = item_i.write_value;
              frame_length_d   = hcfs_pkg::FrameLenSet;
            end
            default: begin
              frame_bytes_d[2] = hcfs_pkg::LenByteDelay;
              frame_bytes_d[3] = hcfs_pkg::CmdDelay;
              frame_bytes_d[4] = item_i.delay_value[15:8];
              frame_bytes_d[5] = item_i.delay_value[7:0];
              frame_length_d   = hcfs_pkg::FrameLenDelay;
            end
          endcase
          byte_position_d   = '0;
          bit_position_d    = '0;
          waiting_for_low_d = 1'b0;
          sending_d         = 1'b1;
        end
      end else if (sending_q) begin
        if (!waiting_for_low_q) begin
          if (item_i.data_line) begin
            clock_level_d     = !cur_bit;
            waiting_for_low_d = 1'b1;
          end
        end else if (!item_i.data_line) begin
          waiting_for_low_d = 1'b0;
          if (bit_position_q == 3'd7) begin
            bit_position_d  = '0;
            byte_position_d = byte_next;
            if (byte_next >= frame_length_q) begin
              sending_d       = 1'b0;
              done            = 1'b1;
              clock_level_d   = 1'b1;
              byte_position_d = '0;
            end
          end else begin
            bit_position_d = bit_position_q + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_length_q    <= '0;
      byte_position_q   <= '0;
      bit_position_q    <= '0;
      waiting_for_low_q <= 1'b0;
      sending_q         <= 1'b0;
      clock_level_q     <= 1'b1;
    end else begin
      frame_length_q    <= frame_length_d;
      byte_position_q   <= byte_position_d;
      bit_position_q    <= bit_position_d;
      waiting_for_low_q <= waiting_for_low_d;
      sending_q         <= sending_d;
      clock_level_q     <= clock_level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_bytes_q <= frame_bytes_d;
  end

  assign res_o.clock_line = clock_level_d;
  assign res_o.busy_res   = sending_d;
  assign res_o.frame_done = done;
  assign res_o.rejected   = rej;

  assign status_o.sending         = sending_q;
  assign status_o.clock_level     = clock_level_q;
  assign status_o.waiting_for_low = waiting_for_low_q;

endmodule

// ===== sv/handshake_command_frame_sender_top.sv =====
// Top level of the command frame sender: command register, engine, result register.
// Depends on hcfs_pkg, hcfs_if, hcfs_engine and assert_macros.svh.
//
// Commands arrive on cmd_i, one transaction per item: a tick carries one sample of
// the partner's data line, and a start builds a get, set or delay frame. Every
// command gives exactly one result transaction on res_o with the driven clock
// level, the busy flag, the frame-done flag and the reject flag.
// A command is held in the command register, then runs through the frame engine
// into the result register. One command is accepted in every cycle as long as
// results are taken; the frame engine's state update is the only loop.
// When the receiver stalls, the result register holds its transaction and the
// command register can hold one more item; once it is full, cmd_i.ready drops
// until res_o.ready returns. A start that arrives while a frame is in progress is
// rejected and leaves the frame untouched.
// Reset clears both registers and the engine: no frame in progress and the clock
// line high. The frame store itself is not cleared; a frame is always written in
// full before it is sent.
`include "assert_macros.svh"

module handshake_command_frame_sender_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  hcfs_cmd_if.sink          cmd_i,
  hcfs_res_if.source        res_o
);

  logic               cmd_valid_q, cmd_valid_d;
  hcfs_pkg::cmd_t     cmd_q;
  logic               res_valid_q, res_valid_d;
  hcfs_pkg::res_t     res_q;
  hcfs_pkg::res_t     eng_res;
  hcfs_pkg::status_t  eng_status;
  logic               res_free;
  logic               step;
  logic               cmd_take;

  assign res_free    = !res_valid_q || res_o.ready;
  assign step        = cmd_valid_q && res_free;
  assign cmd_i.ready = !cmd_valid_q || step;
  assign cmd_take    = cmd_i.valid && cmd_i.ready;

  assign cmd_valid_d = cmd_take || (cmd_valid_q && !step);
  assign res_valid_d = step || (res_valid_q && !res_o.ready);

  hcfs_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (cmd_q),
    .res_o    (eng_res),
    .status_o (eng_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take) begin
      cmd_q <= cmd_i.data;
    end
    if (step) begin
      res_q <= eng_res;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  `HCFS_ASSERT(done_leaves_idle, clk_i, rst_ni,
    res_valid_q && res_q.frame_done |-> !res_q.busy_res && res_q.clock_line)
  `HCFS_ASSERT(reject_only_when_busy, clk_i, rst_ni,
    res_valid_q && res_q.rejected |-> res_q.busy_res)
  `HCFS_ASSERT(idle_clock_high, clk_i, rst_ni,
    !eng_status.sending |-> eng_status.clock_level && !eng_status.waiting_for_low)
  `HCFS_ASSERT_NEVER(step_without_room, clk_i, rst_ni,
    step && res_valid_q && !res_o.ready)

endmodule
